// File: hdl/cubemap_direction_to_texel_macros.svh
// assertion macros used by the checker file
`ifndef CUBEMAP_DIRECTION_TO_TEXEL_MACROS_SVH
`define CUBEMAP_DIRECTION_TO_TEXEL_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CDT_ASSERT_SAME(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("cube map texel check failed");

// consequent must hold in the cycle after the antecedent
`define CDT_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("cube map texel check failed");

`endif

// File: hdl/cdt_pkg.sv
package cdt_pkg;

    // field widths
    localparam int DIR_W       = 16;
    localparam int TILE_DIM_W  = 9;
    localparam int FACE_W      = 3;
    localparam int COL_W       = 8;
    localparam int ROW_W       = 8;
    localparam int IDX_W       = 19;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    // edge length register
    localparam int TILE_DIM_RESET = 64;
    localparam int TILE_DIM_MIN   = 4;

    typedef logic [FACE_W-1:0] t_face;

    // face codes
    localparam t_face FACE_POS_X = 3'd0;
    localparam t_face FACE_NEG_X = 3'd1;
    localparam t_face FACE_POS_Y = 3'd2;
    localparam t_face FACE_NEG_Y = 3'd3;
    localparam t_face FACE_POS_Z = 3'd4;
    localparam t_face FACE_NEG_Z = 3'd5;

endpackage

// File: hdl/cubemap_direction_to_texel.sv
// Cube map face selection: turns a direction vector into a face and a texel.
// Input stream (s side): one transaction carries dir_x, dir_y, dir_z as signed
// 16-bit values of any scale. Output stream (m side): one transaction per input
// with face, texel column, texel row and linear texel index.
// Configuration channel: one write-only register, tile_dim (9 bits), always
// ready; write it only while no item is in flight. Values below 4 act as 4 and
// values above MAX_TILE_DIM act as MAX_TILE_DIM.
// Throughput: one item per cycle, sustained, as long as the m side takes them.
// A result passes through the input, selection and numerator registers, then
// the pipelined restoring divider that yields one quotient bit per stage, then
// the clamp register and the output register.
// Reset (synchronous, active low) empties the pipeline and sets tile_dim to 64.
// When the m side stalls, the output register holds its result and bubbles in
// the pipeline still close up, so the s side keeps accepting until every stage
// is full; then s-side ready drops and nothing is lost or repeated.
module cubemap_direction_to_texel #(
    parameter int MAX_TILE_DIM = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cdt_pkg::TILE_DIM_W-1:0]  i_cfg_data,
    // input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // dir_x [15:0], dir_y [31:16], dir_z [47:32]
    input  logic [cdt_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // output stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // face [2:0], texel_col [10:3], texel_row [18:11], texel_index [37:19], zero pad
    output logic [cdt_pkg::M_TDATA_W-1:0]   o_m_tdata
);

    import cdt_pkg::*;

    localparam int N_W        = $clog2(MAX_TILE_DIM + 1);
    localparam int QUO_W      = N_W;
    localparam int MAG_W      = DIR_W + 1;
    localparam int NUM_W      = MAG_W + N_W;
    localparam int DEN_W      = MAG_W + 1;
    localparam int BASE_W     = FACE_W + N_W;
    localparam int IDX_FULL_W = FACE_W + 2 * N_W;
    localparam int CLAMP_W    = ((N_W > TILE_DIM_W) ? N_W : TILE_DIM_W) + 1;
    localparam int RESET_N    = (TILE_DIM_RESET > MAX_TILE_DIM) ? MAX_TILE_DIM
                                                                : TILE_DIM_RESET;
    // stage map
    localparam int ST_IN      = 0;
    localparam int ST_SEL     = 1;
    localparam int ST_NUM     = 2;
    localparam int ST_DIV0    = 3;
    localparam int ST_CLAMP   = ST_DIV0 + QUO_W;
    localparam int ST_OUT     = ST_CLAMP + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    typedef struct packed {
        t_face             face;
        logic              zero;
        logic [BASE_W-1:0] fn;
    } t_side;

    // ------------------------------------------------------------------
    // configuration register and clamped edge length
    logic [TILE_DIM_W-1:0]  r_tile_dim;
    logic [N_W-1:0]         r_n;
    logic [N_W-1:0]         n_n;

    always_comb begin
        if (CLAMP_W'(r_tile_dim) < CLAMP_W'(TILE_DIM_MIN)) begin
            n_n = N_W'(TILE_DIM_MIN);
        end else if (CLAMP_W'(r_tile_dim) > CLAMP_W'(MAX_TILE_DIM)) begin
            n_n = N_W'(MAX_TILE_DIM);
        end else begin
            n_n = N_W'(r_tile_dim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_dim <= TILE_DIM_W'(TILE_DIM_RESET);
            r_n        <= N_W'(RESET_N);
        end else begin
            if (i_cfg_valid) begin
                r_tile_dim <= i_cfg_data;
            end
            r_n <= n_n;
        end
    end

    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // per-stage valid bits and advance chain
    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES-1:0] w_adv;

    assign w_adv[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || i_m_tready;
    for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_adv
        assign w_adv[k] = !r_valid[k] || w_adv[k+1];
    end

    assign n_valid = {r_valid[NUM_STAGES-2:0], i_s_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (w_adv[k]) begin
                    r_valid[k] <= n_valid[k];
                end
            end
        end
    end

    assign o_s_tready = w_adv[ST_IN];
    assign o_m_tvalid = r_valid[ST_OUT];

    // ------------------------------------------------------------------
    // input register
    logic signed [DIR_W-1:0] r_x;
    logic signed [DIR_W-1:0] r_y;
    logic signed [DIR_W-1:0] r_z;

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_IN]) begin
            r_x <= i_s_tdata[DIR_W-1:0];
            r_y <= i_s_tdata[2*DIR_W-1:DIR_W];
            r_z <= i_s_tdata[3*DIR_W-1:2*DIR_W];
        end
    end

    // ------------------------------------------------------------------
    // major axis, face and face coordinates
    logic signed [MAG_W-1:0] w_xe, w_ye, w_ze;
    logic [MAG_W-1:0]        w_ax, w_ay, w_az;
    logic                    w_xpos, w_ypos, w_zpos;
    t_face                   n_face;
    logic [MAG_W-1:0]        n_m;
    logic signed [MAG_W-1:0] n_s, n_t;

    assign w_xe   = MAG_W'(r_x);
    assign w_ye   = MAG_W'(r_y);
    assign w_ze   = MAG_W'(r_z);
    assign w_ax   = w_xe[MAG_W-1] ? -w_xe : w_xe;
    assign w_ay   = w_ye[MAG_W-1] ? -w_ye : w_ye;
    assign w_az   = w_ze[MAG_W-1] ? -w_ze : w_ze;
    assign w_xpos = !r_x[DIR_W-1] && (r_x != '0);
    assign w_ypos = !r_y[DIR_W-1] && (r_y != '0);
    assign w_zpos = !r_z[DIR_W-1] && (r_z != '0);

    // ties go to y, then z, then x
    always_comb begin
        if (w_ay >= w_ax && w_ay >= w_az) begin
            n_face = w_ypos ? FACE_POS_Y : FACE_NEG_Y;
            n_m    = w_ay;
            n_s    = w_xe;
            n_t    = w_ypos ? w_ze : -w_ze;
        end else if (w_az >= w_ax && w_az >= w_ay) begin
            n_face = w_zpos ? FACE_POS_Z : FACE_NEG_Z;
            n_m    = w_az;
            n_s    = w_zpos ? w_xe : -w_xe;
            n_t    = -w_ye;
        end else begin
            n_face = w_xpos ? FACE_POS_X : FACE_NEG_X;
            n_m    = w_ax;
            n_s    = w_xpos ? -w_ze : w_ze;
            n_t    = -w_ye;
        end
    end

    t_face                   r_sel_face;
    logic [MAG_W-1:0]        r_sel_m;
    logic signed [MAG_W-1:0] r_sel_s, r_sel_t;

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_SEL]) begin
            r_sel_face <= n_face;
            r_sel_m    <= n_m;
            r_sel_s    <= n_s;
            r_sel_t    <= n_t;
        end
    end

    // ------------------------------------------------------------------
    // numerators (c + m) * n, divisor 2m, face offset face * n
    logic signed [MAG_W:0] w_sum_s, w_sum_t;
    logic [NUM_W-1:0]      r_num_c, r_num_r;
    logic [DEN_W-1:0]      r_den;
    t_side                 r_num_side;
    t_side                 n_num_side;

    assign w_sum_s = (MAG_W+1)'(r_sel_s) + $signed({1'b0, r_sel_m});
    assign w_sum_t = (MAG_W+1)'(r_sel_t) + $signed({1'b0, r_sel_m});

    always_comb begin
        n_num_side.face = r_sel_face;
        n_num_side.zero = (r_sel_m == '0);
        n_num_side.fn   = BASE_W'(r_sel_face) * BASE_W'(r_n);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_NUM]) begin
            r_num_c    <= NUM_W'(w_sum_s[MAG_W-1:0]) * NUM_W'(r_n);
            r_num_r    <= NUM_W'(w_sum_t[MAG_W-1:0]) * NUM_W'(r_n);
            r_den      <= {r_sel_m, 1'b0};
            r_num_side <= n_num_side;
        end
    end

    // ------------------------------------------------------------------
    // column and row quotients, side data kept in step with the divider
    logic [QUO_W-1:0] w_quo_c, w_quo_r;
    t_side            r_div_side [QUO_W];

    cdt_div_pipe #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QUO_W (QUO_W)
    ) u_div_col (
        .i_clk (i_clk),
        .i_en  (w_adv[ST_DIV0 +: QUO_W]),
        .i_num (r_num_c),
        .i_den (r_den),
        .o_quo (w_quo_c)
    );

    cdt_div_pipe #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QUO_W (QUO_W)
    ) u_div_row (
        .i_clk (i_clk),
        .i_en  (w_adv[ST_DIV0 +: QUO_W]),
        .i_num (r_num_r),
        .i_den (r_den),
        .o_quo (w_quo_r)
    );

    for (genvar k = 0; k < QUO_W; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (w_adv[ST_DIV0+k]) begin
                r_div_side[k] <= (k == 0) ? r_num_side : r_div_side[(k == 0) ? 0 : k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // clamp to n - 1, centre texel for the zero vector, row offset
    t_side             w_cl_side;
    logic [N_W-1:0]    w_nm1;
    logic [N_W-1:0]    n_col, n_row;
    logic [N_W-1:0]    r_cl_col, r_cl_row;
    t_face             r_cl_face;
    logic [BASE_W-1:0] r_cl_base;

    assign w_cl_side = r_div_side[QUO_W-1];
    assign w_nm1     = r_n - N_W'(1);

    always_comb begin
        if (w_cl_side.zero) begin
            n_col = r_n >> 1;
            n_row = r_n >> 1;
        end else begin
            n_col = (w_quo_c > w_nm1) ? w_nm1 : w_quo_c;
            n_row = (w_quo_r > w_nm1) ? w_nm1 : w_quo_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_CLAMP]) begin
            r_cl_col  <= n_col;
            r_cl_row  <= n_row;
            r_cl_face <= w_cl_side.face;
            r_cl_base <= w_cl_side.fn + BASE_W'(n_row);
        end
    end

    // ------------------------------------------------------------------
    // linear index and output register
    logic [IDX_FULL_W-1:0] w_idx;
    t_face                 r_o_face;
    logic [COL_W-1:0]      r_o_col;
    logic [ROW_W-1:0]      r_o_row;
    logic [IDX_W-1:0]      r_o_idx;

    assign w_idx = IDX_FULL_W'(r_cl_base) * IDX_FULL_W'(r_n) + IDX_FULL_W'(r_cl_col);

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_OUT]) begin
            r_o_face <= r_cl_face;
            r_o_col  <= COL_W'(r_cl_col);
            r_o_row  <= ROW_W'(r_cl_row);
            r_o_idx  <= IDX_W'(w_idx);
        end
    end

    assign o_m_tdata = M_TDATA_W'({r_o_idx, r_o_row, r_o_col, r_o_face});

endmodule

// File: hdl/cdt_div_pipe.sv
module cdt_div_pipe #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 18,
    parameter int QUO_W = 9
) (
    input  logic             i_clk,
    input  logic [QUO_W-1:0] i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    // remainder wide enough for the divisor shifted by every quotient bit
    localparam int REM_W = DEN_W + QUO_W;

    logic [REM_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    // one restoring step per stage, most significant quotient bit first
    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [REM_W-1:0] w_rem_in;
        logic [DEN_W-1:0] w_den_in;
        logic [QUO_W-1:0] w_quo_in;
        logic [REM_W-1:0] w_trial;
        logic [REM_W-1:0] n_rem;
        logic [QUO_W-1:0] n_quo;

        if (k == 0) begin : g_first
            assign w_rem_in = REM_W'(i_num);
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_den_in = r_den[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        assign w_trial = REM_W'(w_den_in) << (QUO_W - 1 - k);

        // subtract when the shifted divisor fits
        always_comb begin
            n_rem = w_rem_in;
            n_quo = w_quo_in;
            if (w_rem_in >= w_trial) begin
                n_rem = w_rem_in - w_trial;
                n_quo = w_quo_in | (QUO_W'(1) << (QUO_W - 1 - k));
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem;
                r_den[k] <= w_den_in;
                r_quo[k] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

// File: hdl/cdt_checker.sv
`include "cubemap_direction_to_texel_macros.svh"

module cdt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_s_tready,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic [cdt_pkg::M_TDATA_W-1:0] o_m_tdata
);

    import cdt_pkg::*;

    // output side state seen out of reset
    logic w_stall;
    logic w_out_live;

    assign w_stall    = i_rst_n && o_m_tvalid && !i_m_tready;
    assign w_out_live = i_rst_n && o_m_tvalid;

    // a stalled result stays put
    `CDT_ASSERT_NEXT(a_out_hold, i_clk, w_stall, o_m_tvalid && $stable(o_m_tdata))

    // reset empties the pipeline
    `CDT_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_m_tvalid)

    // with the output register empty every stage can move, so input is taken
    `CDT_ASSERT_SAME(a_empty_ready, i_clk, i_rst_n && !o_m_tvalid, o_s_tready)

    // only the six real faces come out
    `CDT_ASSERT_SAME(a_face_range, i_clk, w_out_live, o_m_tdata[FACE_W-1:0] <= FACE_NEG_Z)

endmodule

bind cubemap_direction_to_texel cdt_checker u_cdt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
